[rtl/core/pps_pkg.sv]
package pps_pkg;

  localparam logic [1:0] MODE_PUBLISH     = 2'd0;
  localparam logic [1:0] MODE_SUBSCRIBE   = 2'd1;
  localparam logic [1:0] MODE_UNSUBSCRIBE = 2'd2;
  localparam logic [1:0] MODE_UNSUB_ALL   = 2'd3;

  localparam logic [1:0] ERR_OK       = 2'd0;
  localparam logic [1:0] ERR_LIMIT    = 2'd1;
  localparam logic [1:0] ERR_RESERVED = 2'd2;
  localparam logic [1:0] ERR_PRIORITY = 2'd3;

  localparam int SIG_W  = 6;
  localparam int PRIO_W = 6;
  localparam int LIM_W  = 7;

  typedef struct packed {
    logic [5:0] subscriber;
    logic       has_subscriber;
    logic [1:0] error_code;
    logic       last;
  } result_t;

endpackage

[rtl/core/pps_mem.sv]
module pps_mem #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/core/pps_pick.sv]
module pps_pick #(
  parameter int WIDTH = 32,
  parameter int IW    = 5
) (
  input  logic [WIDTH-1:0] bits,
  output logic [IW-1:0]    top_idx,
  output logic [WIDTH-1:0] rest
);

  // Highest set bit wins: later iterations override earlier ones.
  always_comb begin
    top_idx = '0;
    for (int i = 0; i < WIDTH; i++) begin
      if (bits[i]) begin
        top_idx = IW'(i);
      end
    end
    rest = bits & ~(WIDTH'(1) << top_idx);
  end

endmodule

[rtl/core/pps_seq.sv]
module pps_seq #(
  parameter int MAX_SUBSCRIBERS   = 32,
  parameter int MEM_DEPTH         = 64,
  parameter int FIRST_USER_SIGNAL = 4
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [pps_pkg::LIM_W-1:0]   lim,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  mode,
  input  logic [pps_pkg::SIG_W-1:0]   signal,
  input  logic [pps_pkg::PRIO_W-1:0]  priority_req,
  output logic                        out_valid,
  input  logic                        out_ready,
  output pps_pkg::result_t            res
);

  localparam int MW = MAX_SUBSCRIBERS;
  localparam int AW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int IW = (MW > 1) ? $clog2(MW) : 1;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_RMW, S_PUB_RD, S_PUB_EMIT, S_UA_RD, S_UA_WR, S_ONE
  } state_t;

  state_t                       state;
  logic [AW-1:0]                clr_addr;
  logic [AW-1:0]                op_addr;
  logic                         op_set;
  logic [MW-1:0]                op_mask;
  logic [pps_pkg::LIM_W-1:0]    ua_sig;
  logic [MW-1:0]                scan;
  logic [1:0]                   err_hold;

  logic                         mem_rd_en;
  logic [AW-1:0]                mem_rd_addr;
  logic [MW-1:0]                mem_rd_data;
  logic                         mem_wr_en;
  logic [AW-1:0]                mem_wr_addr;
  logic [MW-1:0]                mem_wr_data;

  logic [IW-1:0]                pick_idx;
  logic [MW-1:0]                pick_rest;

  logic                         accept;
  logic                         slot_free;
  logic                         prio_ok;
  logic                         sig_in_lim;
  logic                         sig_reserved;
  logic                         in_err;
  logic [1:0]                   in_err_code;
  logic                         in_rd;
  logic                         in_ua;
  logic                         ua_more;
  logic [MW-1:0]                in_mask;

  pps_mem #(
    .WIDTH (MW),
    .DEPTH (MEM_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

  pps_pick #(
    .WIDTH (MW),
    .IW    (IW)
  ) u_pick (
    .bits    (scan),
    .top_idx (pick_idx),
    .rest    (pick_rest)
  );

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;
  assign ua_more   = ua_sig < lim;

  assign prio_ok      = (priority_req != '0) &&
                        (pps_pkg::LIM_W'(priority_req) <= pps_pkg::LIM_W'(MAX_SUBSCRIBERS));
  assign sig_in_lim   = pps_pkg::LIM_W'(signal) < lim;
  assign sig_reserved = pps_pkg::LIM_W'(signal) < pps_pkg::LIM_W'(FIRST_USER_SIGNAL);
  assign in_mask      = MW'(1) << (priority_req - pps_pkg::PRIO_W'(1));

  // Sort the incoming beat: immediate error, table read, or sweep.
  always_comb begin
    in_err      = 1'b0;
    in_err_code = pps_pkg::ERR_OK;
    in_rd       = 1'b0;
    in_ua       = 1'b0;
    if (mode == pps_pkg::MODE_PUBLISH) begin
      if (!sig_in_lim) begin
        in_err      = 1'b1;
        in_err_code = pps_pkg::ERR_LIMIT;
      end else begin
        in_rd = 1'b1;
      end
    end else if (!prio_ok) begin
      in_err      = 1'b1;
      in_err_code = pps_pkg::ERR_PRIORITY;
    end else if (mode == pps_pkg::MODE_UNSUB_ALL) begin
      in_ua = 1'b1;
    end else if (sig_reserved) begin
      in_err      = 1'b1;
      in_err_code = pps_pkg::ERR_RESERVED;
    end else if (!sig_in_lim) begin
      in_err      = 1'b1;
      in_err_code = pps_pkg::ERR_LIMIT;
    end else begin
      in_rd = 1'b1;
    end
  end

  always_comb begin
    mem_rd_en   = 1'b0;
    mem_rd_addr = signal[AW-1:0];
    mem_wr_en   = 1'b0;
    mem_wr_addr = op_addr;
    mem_wr_data = '0;
    unique case (state)
      S_CLEAR: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = clr_addr;
      end
      S_IDLE: begin
        mem_rd_en = accept && in_rd;
      end
      S_RMW: begin
        mem_wr_en   = 1'b1;
        mem_wr_data = op_set ? (mem_rd_data | op_mask) : (mem_rd_data & ~op_mask);
      end
      S_UA_RD: begin
        mem_rd_en   = ua_more;
        mem_rd_addr = ua_sig[AW-1:0];
      end
      S_UA_WR: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = ua_sig[AW-1:0];
        mem_wr_data = mem_rd_data & ~op_mask;
      end
      S_PUB_RD, S_PUB_EMIT, S_ONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(MEM_DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            op_addr  <= signal[AW-1:0];
            op_set   <= (mode == pps_pkg::MODE_SUBSCRIBE);
            op_mask  <= in_mask;
            ua_sig   <= pps_pkg::LIM_W'(FIRST_USER_SIGNAL);
            err_hold <= in_err_code;
            if (in_err) begin
              if (slot_free) begin
                out_valid          <= 1'b1;
                res.subscriber     <= '0;
                res.has_subscriber <= 1'b0;
                res.error_code     <= in_err_code;
                res.last           <= 1'b1;
              end else begin
                state <= S_ONE;
              end
            end else if (in_ua) begin
              state <= S_UA_RD;
            end else if (mode == pps_pkg::MODE_PUBLISH) begin
              state <= S_PUB_RD;
            end else begin
              state <= S_RMW;
            end
          end
        end
        S_RMW: begin
          // Write back once, then report done.
          err_hold <= pps_pkg::ERR_OK;
          state    <= S_ONE;
          if (slot_free) begin
            out_valid          <= 1'b1;
            res.subscriber     <= '0;
            res.has_subscriber <= 1'b0;
            res.error_code     <= pps_pkg::ERR_OK;
            res.last           <= 1'b1;
            state              <= S_IDLE;
          end
        end
        S_PUB_RD: begin
          scan     <= mem_rd_data;
          err_hold <= pps_pkg::ERR_OK;
          if (mem_rd_data == '0) begin
            state <= S_ONE;
          end else begin
            state <= S_PUB_EMIT;
          end
        end
        S_PUB_EMIT: begin
          if (slot_free) begin
            out_valid          <= 1'b1;
            res.subscriber     <= 6'(pick_idx) + 6'd1;
            res.has_subscriber <= 1'b1;
            res.error_code     <= pps_pkg::ERR_OK;
            res.last           <= (pick_rest == '0);
            scan               <= pick_rest;
            if (pick_rest == '0) begin
              state <= S_IDLE;
            end
          end
        end
        S_UA_RD: begin
          if (ua_more) begin
            state <= S_UA_WR;
          end else begin
            err_hold <= pps_pkg::ERR_OK;
            state    <= S_ONE;
          end
        end
        S_UA_WR: begin
          ua_sig <= ua_sig + pps_pkg::LIM_W'(1);
          state  <= S_UA_RD;
        end
        S_ONE: begin
          if (slot_free) begin
            out_valid          <= 1'b1;
            res.subscriber     <= '0;
            res.has_subscriber <= 1'b0;
            res.error_code     <= err_hold;
            res.last           <= 1'b1;
            state              <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/core/priority_publish_subscribe_table.sv]
// Flow: an error beat is answered from the idle state (or via S_ONE when the result slot
// is busy); subscribe and unsubscribe read the entry, write it back in S_RMW and report;
// publish reads the entry in S_PUB_RD, then emits one result per subscriber (or one status
// beat if none). Requests go one at a time through a one-port-read, one-port-write table
// memory; unsubscribe-all reads and writes each signal from first_user up to the limit.
// Reset: num_signals returns to 64 and a clearing pass zeroes min(TABLE_DEPTH, 64) entries.
module priority_publish_subscribe_table #(
  parameter int MAX_SUBSCRIBERS   = 32,
  parameter int TABLE_DEPTH       = 64,
  parameter int FIRST_USER_SIGNAL = 4
) (
  input  logic        clk,
  input  logic        rst,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // request channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  mode,
  input  logic [5:0]  signal,
  input  logic [5:0]  priority_req,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  subscriber,
  output logic        has_subscriber,
  output logic [1:0]  error_code,
  output logic        last
);

  // Signal numbers are six bits wide, so entries past 63 can never be reached;
  // size the table to what the signal field can address.
  localparam int MEM_DEPTH = (TABLE_DEPTH < 64) ? TABLE_DEPTH : 64;

  logic [pps_pkg::LIM_W-1:0] num_signals;
  logic [pps_pkg::LIM_W-1:0] lim;
  pps_pkg::result_t          res;

  // Register 0 (num_signals) sits at byte address 0; decode on the word bit only.
  always_ff @(posedge clk) begin
    if (rst) begin
      num_signals <= pps_pkg::LIM_W'(64);
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      num_signals <= pwdata[pps_pkg::LIM_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {{(32 - pps_pkg::LIM_W){1'b0}}, num_signals};

  // Clamp the signal limit to the table size.
  assign lim = (num_signals > pps_pkg::LIM_W'(MEM_DEPTH)) ?
               pps_pkg::LIM_W'(MEM_DEPTH) : num_signals;

  // Sequencer: decode the request, read-modify-write the bitmap memory,
  // and drain publish bitmaps one subscriber per beat, highest priority first.
  pps_seq #(
    .MAX_SUBSCRIBERS   (MAX_SUBSCRIBERS),
    .MEM_DEPTH         (MEM_DEPTH),
    .FIRST_USER_SIGNAL (FIRST_USER_SIGNAL)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .lim          (lim),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .mode         (mode),
    .signal       (signal),
    .priority_req (priority_req),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .res          (res)
  );

  assign subscriber     = res.subscriber;
  assign has_subscriber = res.has_subscriber;
  assign error_code     = res.error_code;
  assign last           = res.last;

endmodule

[tb/sv/pps_delivery_checker.sv]
`timescale 1ns / 100ps

module pps_delivery_checker #(
  parameter int          MAX_SUBS         = 32,
  parameter int          TABLE_DEPTH      = 64,
  parameter int          FIRST_USER       = 4,
  parameter logic [2:0]  NUM_SIGNALS_ADDR = 3'd0
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  mode,
  input  logic [5:0]  signal,
  input  logic [5:0]  priority_req,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [5:0]  subscriber,
  input  logic        has_subscriber,
  input  logic [1:0]  error_code,
  input  logic        last,
  output int          failures,
  output int          pending,
  output int          checked
);

  logic [MAX_SUBS-1:0]       sub_bitmaps [TABLE_DEPTH];
  logic [pps_pkg::LIM_W-1:0] num_signals_q;
  pps_pkg::result_t          deliveries_due [$];
  pps_pkg::result_t          want;
  int                        fail_count;
  int                        checked_count;

  // Push one expected beat per subscriber (or one status beat) and update the bitmaps.
  function automatic void predict_deliveries(input logic [1:0] m, input logic [5:0] s,
                                             input logic [5:0] p);
    int                  lim;
    logic [MAX_SUBS-1:0] bits;
    pps_pkg::result_t    r;
    lim = (num_signals_q > TABLE_DEPTH) ? TABLE_DEPTH : int'(num_signals_q);
    r = '{subscriber: 6'd0, has_subscriber: 1'b0, error_code: pps_pkg::ERR_OK,
          last: 1'b1};
    if (m == pps_pkg::MODE_PUBLISH) begin
      if (s >= lim) begin
        r.error_code = pps_pkg::ERR_LIMIT;
      end else if (sub_bitmaps[s] != '0) begin
        bits = sub_bitmaps[s];
        for (int b = MAX_SUBS - 1; b >= 0; b--) begin
          if (bits[b]) begin
            bits[b] = 1'b0;
            deliveries_due.push_back('{subscriber: 6'(b + 1), has_subscriber: 1'b1,
                                       error_code: pps_pkg::ERR_OK, last: (bits == '0)});
          end
        end
        return;
      end
      deliveries_due.push_back(r);
      return;
    end
    // priority is checked before anything else for every table update
    if (p < 1 || p > MAX_SUBS) begin
      r.error_code = pps_pkg::ERR_PRIORITY;
    end else if (m == pps_pkg::MODE_UNSUB_ALL) begin
      for (int i = FIRST_USER; i < lim; i++) begin
        sub_bitmaps[i][p-1] = 1'b0;
      end
    end else if (s < FIRST_USER) begin
      r.error_code = pps_pkg::ERR_RESERVED;
    end else if (s >= lim) begin
      r.error_code = pps_pkg::ERR_LIMIT;
    end else begin
      sub_bitmaps[s][p-1] = (m == pps_pkg::MODE_SUBSCRIBE);
    end
    deliveries_due.push_back(r);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        sub_bitmaps[i] = '0;
      end
      num_signals_q = pps_pkg::LIM_W'(64);
      deliveries_due.delete();
      fail_count    = 0;
      checked_count = 0;
    end else begin
      // the register is selected by the word bit of the address
      if (psel && penable && pwrite && pready && paddr[2] == NUM_SIGNALS_ADDR[2]) begin
        num_signals_q = pwdata[pps_pkg::LIM_W-1:0];
      end
      if (out_valid && out_ready) begin
        if (deliveries_due.size() == 0) begin
          $error("result beat with nothing pending: subscriber %0d error_code %0d last %0d",
                 subscriber, error_code, last);
          fail_count++;
        end else begin
          want = deliveries_due.pop_front();
          checked_count++;
          if (subscriber !== want.subscriber) begin
            $error("subscriber: expected %0d, actual %0d", want.subscriber, subscriber);
            fail_count++;
          end
          if (has_subscriber !== want.has_subscriber) begin
            $error("has_subscriber: expected %0d, actual %0d", want.has_subscriber,
                   has_subscriber);
            fail_count++;
          end
          if (error_code !== want.error_code) begin
            $error("error_code: expected %0d, actual %0d", want.error_code, error_code);
            fail_count++;
          end
          if (last !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, last);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        predict_deliveries(mode, signal, priority_req);
      end
    end
    failures <= fail_count;
    pending  <= deliveries_due.size();
    checked  <= checked_count;
  end

endmodule

[tb/sv/priority_publish_subscribe_table_tb.sv]
`timescale 1ns / 100ps

module priority_publish_subscribe_table_tb;

  localparam int         MAX_SUBS         = 32;
  localparam int         TABLE_DEPTH      = 64;
  localparam int         FIRST_USER       = 4;
  localparam logic [2:0] NUM_SIGNALS_ADDR = 3'd0;
  // Unsubscribe-all with a full signal range is the slowest single request;
  // give it room plus some slack.
  localparam int         SETTLE_CYCLES    = 2 * (TABLE_DEPTH - FIRST_USER) + 30;
  localparam int         CYCLE_LIMIT      = 1_000_000;
  localparam int         PHASE_ITEMS      = 100;

  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        psel         = 1'b0;
  logic        penable      = 1'b0;
  logic        pwrite       = 1'b0;
  logic [2:0]  paddr        = '0;
  logic [31:0] pwdata       = '0;
  logic        in_valid     = 1'b0;
  logic [1:0]  mode         = pps_pkg::MODE_PUBLISH;
  logic [5:0]  signal       = '0;
  logic [5:0]  priority_req = '0;
  logic        out_ready    = 1'b1;

  logic [31:0] prdata;
  logic        pready;
  logic        in_ready;
  logic        out_valid;
  logic [5:0]  subscriber;
  logic        has_subscriber;
  logic [1:0]  error_code;
  logic        last;

  int fail_count;
  int results_pending;
  int results_checked;

  // Percent chance per cycle of a sender gap / receiver stall in the current phase.
  int idle_pct    = 0;
  int stall_pct   = 0;
  int items_sent  = 0;
  int cur_limit   = 64;
  int cycle_count = 0;

  always #5 clk = ~clk;

  // Receiver side: stall out_ready at random while a stall phase is active.
  always @(posedge clk) begin
    out_ready <= (stall_pct == 0) || (int'($urandom_range(99)) >= stall_pct);
  end

  // Watchdog: a hung handshake or a missing result ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("priority_publish_subscribe_table_tb failed");
      $finish;
    end
  end

  priority_publish_subscribe_table #(
    .MAX_SUBSCRIBERS  (MAX_SUBS),
    .TABLE_DEPTH      (TABLE_DEPTH),
    .FIRST_USER_SIGNAL(FIRST_USER)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .mode          (mode),
    .signal        (signal),
    .priority_req  (priority_req),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .subscriber    (subscriber),
    .has_subscriber(has_subscriber),
    .error_code    (error_code),
    .last          (last)
  );

  pps_delivery_checker #(
    .MAX_SUBS        (MAX_SUBS),
    .TABLE_DEPTH     (TABLE_DEPTH),
    .FIRST_USER      (FIRST_USER),
    .NUM_SIGNALS_ADDR(NUM_SIGNALS_ADDR)
  ) delivery_check (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .mode          (mode),
    .signal        (signal),
    .priority_req  (priority_req),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .subscriber    (subscriber),
    .has_subscriber(has_subscriber),
    .error_code    (error_code),
    .last          (last),
    .failures      (fail_count),
    .pending       (results_pending),
    .checked       (results_checked)
  );

  // Send one request beat. Insert random gaps first, then hold valid and payload
  // until the beat is taken. Valid is left high so back-to-back beats need no toggle.
  task automatic send_request(input logic [1:0] m, input logic [5:0] s, input logic [5:0] p);
    while (idle_pct != 0 && int'($urandom_range(99)) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    mode         <= m;
    signal       <= s;
    priority_req <= p;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // Drop valid, let every expected result drain, then give the block time
  // to settle before touching the register.
  task automatic finish_outstanding();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write: setup, then access until pready is seen.
  task automatic write_num_signals(input int value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= NUM_SIGNALS_ADDR;
    pwdata  <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cur_limit = (value > TABLE_DEPTH) ? TABLE_DEPTH : value;
  endtask

  // Bias signals toward a few user signals so bitmaps fill up and publishes
  // fan out; keep a share of arbitrary signals for the error paths.
  function automatic logic [5:0] pick_signal();
    int roll;
    int span;
    roll = $urandom_range(99);
    if (cur_limit <= FIRST_USER || roll < 10) begin
      return 6'($urandom_range(63));
    end
    span = cur_limit - FIRST_USER;
    if (roll < 80 && span > 8) begin
      span = 8;
    end
    return 6'(FIRST_USER + $urandom_range(span - 1));
  endfunction

  // Subscribe most priorities to one signal, then publish it for a long burst.
  task automatic fill_and_publish(input logic [5:0] s);
    for (int p = 1; p <= MAX_SUBS; p++) begin
      if ($urandom_range(3) != 0) begin
        send_request(pps_pkg::MODE_SUBSCRIBE, s, 6'(p));
      end
    end
    send_request(pps_pkg::MODE_PUBLISH, s, 6'($urandom_range(63)));
  endtask

  task automatic random_requests(input int count);
    int target;
    int roll;
    target = items_sent + count;
    while (items_sent < target) begin
      roll = $urandom_range(99);
      if (roll < 3 && cur_limit > FIRST_USER) begin
        fill_and_publish(pick_signal());
      end else if (roll < 40) begin
        send_request(pps_pkg::MODE_SUBSCRIBE, pick_signal(),
                     6'($urandom_range(1, MAX_SUBS)));
      end else if (roll < 55) begin
        send_request(pps_pkg::MODE_UNSUBSCRIBE, pick_signal(),
                     6'($urandom_range(1, MAX_SUBS)));
      end else if (roll < 80) begin
        send_request(pps_pkg::MODE_PUBLISH, pick_signal(), 6'($urandom_range(63)));
      end else if (roll < 85) begin
        send_request(pps_pkg::MODE_UNSUB_ALL, 6'($urandom_range(63)),
                     6'($urandom_range(1, MAX_SUBS)));
      end else begin
        // noise: any mode, signal and priority, bad ones included
        send_request(2'($urandom_range(3)), 6'($urandom_range(63)),
                     6'($urandom_range(63)));
      end
    end
  endtask

  task automatic run_phase(input int limit_value, input int idle, input int stall);
    finish_outstanding();
    write_num_signals(limit_value);
    idle_pct  = idle;
    stall_pct = stall;
    random_requests(PHASE_ITEMS);
  endtask

  initial begin
    // Hold reset, then release it; the clearing pass after it is absorbed by in_ready.
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed part at the reset limit of 64 signals.
    send_request(pps_pkg::MODE_PUBLISH, 6'd10, 6'd0);        // nobody subscribed yet
    send_request(pps_pkg::MODE_SUBSCRIBE, 6'd10, 6'd1);
    send_request(pps_pkg::MODE_SUBSCRIBE, 6'd10, 6'd32);
    send_request(pps_pkg::MODE_SUBSCRIBE, 6'd10, 6'd17);
    send_request(pps_pkg::MODE_SUBSCRIBE, 6'd10, 6'd17);     // bit already set
    send_request(pps_pkg::MODE_PUBLISH, 6'd10, 6'd63);       // 32, 17, 1 in that order
    send_request(pps_pkg::MODE_UNSUBSCRIBE, 6'd10, 6'd17);
    send_request(pps_pkg::MODE_UNSUBSCRIBE, 6'd10, 6'd17);   // bit already clear
    send_request(pps_pkg::MODE_PUBLISH, 6'd10, 6'd0);
    send_request(pps_pkg::MODE_PUBLISH, 6'd0, 6'd0);         // reserved signal may be published
    send_request(pps_pkg::MODE_SUBSCRIBE, 6'd3, 6'd5);       // reserved signal
    send_request(pps_pkg::MODE_SUBSCRIBE, 6'd3, 6'd0);       // priority wins over reserved
    send_request(pps_pkg::MODE_UNSUBSCRIBE, 6'd63, 6'd33);   // priority just past the top
    send_request(pps_pkg::MODE_SUBSCRIBE, 6'd63, 6'd63);
    send_request(pps_pkg::MODE_SUBSCRIBE, 6'd63, 6'd32);     // top signal, top priority
    send_request(pps_pkg::MODE_SUBSCRIBE, 6'd4, 6'd32);      // first user signal
    send_request(pps_pkg::MODE_UNSUB_ALL, 6'd0, 6'd32);      // signal field is ignored
    send_request(pps_pkg::MODE_PUBLISH, 6'd63, 6'd0);
    send_request(pps_pkg::MODE_PUBLISH, 6'd10, 6'd0);
    send_request(pps_pkg::MODE_UNSUB_ALL, 6'd63, 6'd0);      // bad priority
    send_request(pps_pkg::MODE_UNSUBSCRIBE, 6'd2, 6'd1);

    // Narrow the range to reach the limit error on publish and subscribe requests.
    finish_outstanding();
    write_num_signals(20);
    send_request(pps_pkg::MODE_PUBLISH, 6'd63, 6'd0);
    send_request(pps_pkg::MODE_SUBSCRIBE, 6'd20, 6'd1);
    send_request(pps_pkg::MODE_SUBSCRIBE, 6'd40, 6'd40);     // priority checked first

    // Random phases: each one sets a limit, a sender-gap chance and a receiver-stall chance.
    run_phase(20, 0, 0);
    run_phase(4, 80, 0);       // no user signal left at all
    run_phase(100, 0, 80);     // above the table depth
    run_phase(64, 20, 20);
    run_phase(37, 0, 0);

    finish_outstanding();
    $display("Ran %0d requests with signal limits 64, 20, 4, 100 and 37, %0d results compared,",
             items_sent, results_checked);
    $display("through idle-free, sender-gap, receiver-stall and mixed-pressure phases.");
    if (fail_count == 0) begin
      $display("priority_publish_subscribe_table_tb passed");
    end else begin
      $display("priority_publish_subscribe_table_tb failed");
    end
    $finish;
  end

endmodule
